/* rtl/jdc_pkg.sv */
// Shared types, constants and lookup tables of the Julian day date converter.
// Depends on nothing; every other file of the block imports it.
package jdc_pkg;

   // Field widths.
   localparam int MONTH_W  = 4;
   localparam int DAY_W    = 5;
   localparam int YEAR_W   = 14;
   localparam int SERIAL_W = 23;
   localparam int OFFSET_W = 21;
   localparam int JDN_W    = 25;   // signed day number after the offset is added

   // Opcodes.
   localparam logic OP_DATE   = 1'b0;
   localparam logic OP_SERIAL = 1'b1;

   // Two-digit years are taken as years of the twentieth century.
   localparam logic [YEAR_W-1:0] YEAR_BIAS_LIMIT = 14'd100;
   localparam logic [YEAR_W-1:0] YEAR_BIAS       = 14'd1900;

   // Day numbers of 0001-01-01 and 9999-12-31.
   localparam logic signed [JDN_W-1:0] JDN_MIN = 25'sd1721426;
   localparam logic signed [JDN_W-1:0] JDN_MAX = 25'sd5373484;

   // Constants of the conversion formulas.
   localparam logic [24:0] JDN_SHIFT   = 25'd68569;
   localparam logic [24:0] CYCLE_DAYS  = 25'd146097;    // days in 400 years
   localparam logic [32:0] CYCLE_RECIP = 33'd229;       // floor(2^25 / 146097)
   localparam int          CYCLE_SHIFT = 25;
   localparam logic [44:0] YEAR_RECIP  = 45'd188143545; // ceil(2^36 * 4000 / 1461001)
   localparam int          YEAR_SHIFT  = 36;
   localparam logic [25:0] MONTH_RECIP = 26'd68563;     // ceil(2^21 * 80 / 2447)
   localparam int          MONTH_SHIFT = 21;

   typedef struct packed {
      logic                    valid;
      logic signed [JDN_W-1:0] jdn;
   } jdc_jdn_type;

   typedef struct packed {
      logic                valid;
      logic                range_err;
      logic [SERIAL_W-1:0] serial;
      logic [MONTH_W-1:0]  month;
      logic [DAY_W-1:0]    day;
      logic [YEAR_W-1:0]   year;
   } jdc_date_type;

   // Month term of the date to day number formula, 367 * (m - 2 - 12a) / 12.
   function automatic logic [8:0] month_days_ahead(input logic [MONTH_W-1:0] month);
      logic [8:0] days;
      case (month)
         4'd0:    days = 9'd305;
         4'd1:    days = 9'd336;
         4'd2:    days = 9'd367;
         4'd3:    days = 9'd30;
         4'd4:    days = 9'd61;
         4'd5:    days = 9'd91;
         4'd6:    days = 9'd122;
         4'd7:    days = 9'd152;
         4'd8:    days = 9'd183;
         4'd9:    days = 9'd214;
         4'd10:   days = 9'd244;
         4'd11:   days = 9'd275;
         4'd12:   days = 9'd305;
         4'd13:   days = 9'd336;
         4'd14:   days = 9'd367;
         default: days = 9'd397;
      endcase
      return days;
   endfunction

   // Days before a month of the March-based year, 2447 * mm / 80.
   function automatic logic [8:0] days_before_month(input logic [MONTH_W-1:0] mm);
      logic [8:0] days;
      case (mm)
         4'd0:    days = 9'd0;
         4'd1:    days = 9'd30;
         4'd2:    days = 9'd61;
         4'd3:    days = 9'd91;
         4'd4:    days = 9'd122;
         4'd5:    days = 9'd152;
         4'd6:    days = 9'd183;
         4'd7:    days = 9'd214;
         4'd8:    days = 9'd244;
         4'd9:    days = 9'd275;
         4'd10:   days = 9'd305;
         4'd11:   days = 9'd336;
         4'd12:   days = 9'd367;
         4'd13:   days = 9'd397;
         4'd14:   days = 9'd428;
         default: days = 9'd458;
      endcase
      return days;
   endfunction

endpackage

/* rtl/jdc_fwd.sv */
// Front pipeline: source day number from date fields or serial, plus the offset.
// Four register stages. Depends on jdc_pkg.
module jdc_fwd
   import jdc_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   input  logic                       opcode,
   input  logic [MONTH_W-1:0]         in_month,
   input  logic [DAY_W-1:0]           in_day,
   input  logic [YEAR_W-1:0]          in_year,
   input  logic [SERIAL_W-1:0]        in_serial,
   input  logic signed [OFFSET_W-1:0] day_offset,
   output jdc_jdn_type                jdn_out
);

   // Stage 1: year bias, year sums and the small additive terms.
   logic                       s1_valid_ff, s1_valid_in;
   logic                       s1_opcode_ff, s1_opcode_in;
   logic [SERIAL_W-1:0]        s1_serial_ff, s1_serial_in;
   logic signed [OFFSET_W-1:0] s1_offset_ff, s1_offset_in;
   logic [14:0]                s1_x2_ff, s1_x2_in;
   logic [14:0]                s1_x4_ff, s1_x4_in;
   logic signed [16:0]         s1_base_ff, s1_base_in;

   // Stage 2: the two products.
   logic                       s2_valid_ff, s2_valid_in;
   logic                       s2_opcode_ff, s2_opcode_in;
   logic [SERIAL_W-1:0]        s2_serial_ff, s2_serial_in;
   logic signed [OFFSET_W-1:0] s2_offset_ff, s2_offset_in;
   logic signed [16:0]         s2_base_ff, s2_base_in;
   logic [24:0]                s2_p2_ff, s2_p2_in;
   logic [26:0]                s2_p4_ff, s2_p4_in;

   // Stage 3: source day number.
   logic                       s3_valid_ff, s3_valid_in;
   logic signed [OFFSET_W-1:0] s3_offset_ff, s3_offset_in;
   logic signed [JDN_W-1:0]    s3_src_ff, s3_src_in;

   // Stage 4: offset added.
   logic                       s4_valid_ff, s4_valid_in;
   logic signed [JDN_W-1:0]    s4_jdn_ff, s4_jdn_in;

   logic [YEAR_W-1:0] year_adj;
   logic              early;
   logic [7:0]        century;
   logic [9:0]        century_x3;
   logic [7:0]        leap_fix;

   always_comb begin
      year_adj = (in_year < YEAR_BIAS_LIMIT) ? in_year + YEAR_BIAS : in_year;
      // January and February count as months of the previous year.
      early = (in_month <= 4'd2);

      s1_valid_in  = in_valid;
      s1_opcode_in = opcode;
      s1_serial_in = in_serial;
      s1_offset_in = day_offset;
      s1_x2_in     = {1'b0, year_adj} + 15'd4800 - {14'b0, early};
      s1_x4_in     = {1'b0, year_adj} + 15'd4900 - {14'b0, early};
      s1_base_in   = $signed({12'b0, in_day}) + $signed({8'b0, month_days_ahead(in_month)})
                     - 17'sd32075;
   end

   always_comb begin
      s2_valid_in  = s1_valid_ff;
      s2_opcode_in = s1_opcode_ff;
      s2_serial_in = s1_serial_ff;
      s2_offset_in = s1_offset_ff;
      s2_base_in   = s1_base_ff;
      s2_p2_in     = {10'b0, s1_x2_ff} * 25'd1461;
      // Multiplying by 5243 and dropping 19 bits divides by 100 exactly here.
      s2_p4_in     = {12'b0, s1_x4_ff} * 27'd5243;
   end

   always_comb begin
      century    = s2_p4_ff[26:19];
      century_x3 = {2'b0, century} + {1'b0, century, 1'b0};
      leap_fix   = century_x3[9:2];

      s3_valid_in  = s2_valid_ff;
      s3_offset_in = s2_offset_ff;
      if (s2_opcode_ff == OP_SERIAL) begin
         s3_src_in = $signed({2'b0, s2_serial_ff});
      end else begin
         s3_src_in = $signed({2'b0, s2_p2_ff[24:2]})
                     + $signed({{8{s2_base_ff[16]}}, s2_base_ff})
                     - $signed({17'b0, leap_fix});
      end
   end

   always_comb begin
      s4_valid_in = s3_valid_ff;
      s4_jdn_in   = s3_src_ff + $signed({{4{s3_offset_ff[OFFSET_W-1]}}, s3_offset_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
         s4_valid_ff <= s4_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_opcode_ff <= s1_opcode_in;
      s1_serial_ff <= s1_serial_in;
      s1_offset_ff <= s1_offset_in;
      s1_x2_ff     <= s1_x2_in;
      s1_x4_ff     <= s1_x4_in;
      s1_base_ff   <= s1_base_in;
      s2_opcode_ff <= s2_opcode_in;
      s2_serial_ff <= s2_serial_in;
      s2_offset_ff <= s2_offset_in;
      s2_base_ff   <= s2_base_in;
      s2_p2_ff     <= s2_p2_in;
      s2_p4_ff     <= s2_p4_in;
      s3_offset_ff <= s3_offset_in;
      s3_src_ff    <= s3_src_in;
      s4_jdn_ff    <= s4_jdn_in;
   end

   assign jdn_out.valid = s4_valid_ff;
   assign jdn_out.jdn   = s4_jdn_ff;

endmodule

/* rtl/jdc_inv.sv */
// Back pipeline: range test and day number to month, day and year.
// Eight register stages and a final combinational step. Depends on jdc_pkg.
module jdc_inv
   import jdc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  jdc_jdn_type  jdn_in,
   output jdc_date_type date_out
);

   // Control and the day number itself travel along every stage.
   logic                s5_valid_ff,  s5_valid_in;
   logic                s5_err_ff,    s5_err_in;
   logic [SERIAL_W-1:0] s5_serial_ff, s5_serial_in;
   logic [22:0]         s5_t1_ff,     s5_t1_in;

   logic                s6_valid_ff,  s6_valid_in;
   logic                s6_err_ff,    s6_err_in;
   logic [SERIAL_W-1:0] s6_serial_ff, s6_serial_in;
   logic [24:0]         s6_n1_ff,     s6_n1_in;
   logic [7:0]          s6_q_ff,      s6_q_in;

   logic                s7_valid_ff,  s7_valid_in;
   logic                s7_err_ff,    s7_err_in;
   logic [SERIAL_W-1:0] s7_serial_ff, s7_serial_in;
   logic [18:0]         s7_rem_ff,    s7_rem_in;
   logic [7:0]          s7_q_ff,      s7_q_in;

   logic                s8_valid_ff,  s8_valid_in;
   logic                s8_err_ff,    s8_err_in;
   logic [SERIAL_W-1:0] s8_serial_ff, s8_serial_in;
   logic [7:0]          s8_t2_ff,     s8_t2_in;
   logic [15:0]         s8_doc_ff,    s8_doc_in;

   logic                s9_valid_ff,  s9_valid_in;
   logic                s9_err_ff,    s9_err_in;
   logic [SERIAL_W-1:0] s9_serial_ff, s9_serial_in;
   logic [7:0]          s9_t2_ff,     s9_t2_in;
   logic [15:0]         s9_doc_ff,    s9_doc_in;
   logic [6:0]          s9_yy_ff,     s9_yy_in;

   logic                s10_valid_ff,  s10_valid_in;
   logic                s10_err_ff,    s10_err_in;
   logic [SERIAL_W-1:0] s10_serial_ff, s10_serial_in;
   logic [7:0]          s10_t2_ff,     s10_t2_in;
   logic [15:0]         s10_doc_ff,    s10_doc_in;
   logic [6:0]          s10_yy_ff,     s10_yy_in;
   logic [17:0]         s10_ydays_ff,  s10_ydays_in;

   logic                s11_valid_ff,  s11_valid_in;
   logic                s11_err_ff,    s11_err_in;
   logic [SERIAL_W-1:0] s11_serial_ff, s11_serial_in;
   logic [7:0]          s11_t2_ff,     s11_t2_in;
   logic [6:0]          s11_yy_ff,     s11_yy_in;
   logic [8:0]          s11_doy_ff,    s11_doy_in;

   logic                s12_valid_ff,  s12_valid_in;
   logic                s12_err_ff,    s12_err_in;
   logic [SERIAL_W-1:0] s12_serial_ff, s12_serial_in;
   logic [7:0]          s12_t2_ff,     s12_t2_in;
   logic [6:0]          s12_yy_ff,     s12_yy_in;
   logic [8:0]          s12_doy_ff,    s12_doy_in;
   logic [MONTH_W-1:0]  s12_mm_ff,     s12_mm_in;

   logic [24:0] t1_full;
   logic [32:0] cyc_prod;
   logic [24:0] cyc_back;
   logic [24:0] rem_full;
   logic        rem_over;
   logic [18:0] rem_fix;
   logic [16:0] doc_plus;
   logic [44:0] yr_prod;
   logic [16:0] doy_full;
   logic [25:0] mon_prod;
   logic [8:0]  day_full;
   logic        late;
   logic [7:0]  cent;
   logic [13:0] cent_years;
   logic [13:0] year_full;

   // Stage 5: range test and shift to the 400-year cycle origin.
   always_comb begin
      t1_full      = jdn_in.jdn + $signed(JDN_SHIFT);
      s5_valid_in  = jdn_in.valid;
      s5_err_in    = (jdn_in.jdn < JDN_MIN) || (jdn_in.jdn > JDN_MAX);
      s5_serial_in = jdn_in.jdn[SERIAL_W-1:0];
      s5_t1_in     = t1_full[22:0];
   end

   // Stage 6: quotient estimate by 146097, low by at most one.
   always_comb begin
      s6_n1_in     = {s5_t1_ff, 2'b00};
      cyc_prod     = {8'b0, s6_n1_in} * CYCLE_RECIP;
      s6_q_in      = cyc_prod[CYCLE_SHIFT +: 8];
      s6_valid_in  = s5_valid_ff;
      s6_err_in    = s5_err_ff;
      s6_serial_in = s5_serial_ff;
   end

   // Stage 7: remainder of the estimate.
   always_comb begin
      cyc_back     = {17'b0, s6_q_ff} * CYCLE_DAYS;
      rem_full     = s6_n1_ff - cyc_back;
      s7_rem_in    = rem_full[18:0];
      s7_q_in      = s6_q_ff;
      s7_valid_in  = s6_valid_ff;
      s7_err_in    = s6_err_ff;
      s7_serial_in = s6_serial_ff;
   end

   // Stage 8: correct the quotient; a quarter of the remainder is the day of the cycle.
   always_comb begin
      rem_over     = (s7_rem_ff >= CYCLE_DAYS[18:0]);
      rem_fix      = rem_over ? s7_rem_ff - CYCLE_DAYS[18:0] : s7_rem_ff;
      s8_t2_in     = s7_q_ff + {7'b0, rem_over};
      s8_doc_in    = rem_fix[17:2];
      s8_valid_in  = s7_valid_ff;
      s8_err_in    = s7_err_ff;
      s8_serial_in = s7_serial_ff;
   end

   // Stage 9: year within the century, 4000 * (t + 1) / 1461001 by reciprocal.
   always_comb begin
      doc_plus     = {1'b0, s8_doc_ff} + 17'd1;
      yr_prod      = {28'b0, doc_plus} * YEAR_RECIP;
      s9_yy_in     = yr_prod[YEAR_SHIFT +: 7];
      s9_t2_in     = s8_t2_ff;
      s9_doc_in    = s8_doc_ff;
      s9_valid_in  = s8_valid_ff;
      s9_err_in    = s8_err_ff;
      s9_serial_in = s8_serial_ff;
   end

   // Stage 10: days in the whole years passed.
   always_comb begin
      s10_ydays_in  = {11'b0, s9_yy_ff} * 18'd1461;
      s10_t2_in     = s9_t2_ff;
      s10_doc_in    = s9_doc_ff;
      s10_yy_in     = s9_yy_ff;
      s10_valid_in  = s9_valid_ff;
      s10_err_in    = s9_err_ff;
      s10_serial_in = s9_serial_ff;
   end

   // Stage 11: day within the March-based year.
   always_comb begin
      doy_full      = {1'b0, s10_doc_ff} - {1'b0, s10_ydays_ff[17:2]} + 17'd31;
      s11_doy_in    = doy_full[8:0];
      s11_t2_in     = s10_t2_ff;
      s11_yy_in     = s10_yy_ff;
      s11_valid_in  = s10_valid_ff;
      s11_err_in    = s10_err_ff;
      s11_serial_in = s10_serial_ff;
   end

   // Stage 12: month of the March-based year, 80 * t / 2447 by reciprocal.
   always_comb begin
      mon_prod      = {17'b0, s11_doy_ff} * MONTH_RECIP;
      s12_mm_in     = mon_prod[MONTH_SHIFT +: MONTH_W];
      s12_doy_in    = s11_doy_ff;
      s12_t2_in     = s11_t2_ff;
      s12_yy_in     = s11_yy_ff;
      s12_valid_in  = s11_valid_ff;
      s12_err_in    = s11_err_ff;
      s12_serial_in = s11_serial_ff;
   end

   // Final step: day, calendar month and year.
   always_comb begin
      day_full   = s12_doy_ff - days_before_month(s12_mm_ff);
      late       = (s12_mm_ff >= 4'd11);
      cent       = s12_t2_ff - 8'd49;
      cent_years = {6'b0, cent} * 14'd100;
      year_full  = cent_years + {7'b0, s12_yy_ff} + {13'b0, late};

      date_out.valid     = s12_valid_ff;
      date_out.range_err = s12_err_ff;
      date_out.serial    = s12_serial_ff;
      date_out.day       = day_full[DAY_W-1:0];
      date_out.month     = late ? s12_mm_ff - 4'd10 : s12_mm_ff + 4'd2;
      date_out.year      = year_full;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff  <= 1'b0;
         s6_valid_ff  <= 1'b0;
         s7_valid_ff  <= 1'b0;
         s8_valid_ff  <= 1'b0;
         s9_valid_ff  <= 1'b0;
         s10_valid_ff <= 1'b0;
         s11_valid_ff <= 1'b0;
         s12_valid_ff <= 1'b0;
      end else begin
         s5_valid_ff  <= s5_valid_in;
         s6_valid_ff  <= s6_valid_in;
         s7_valid_ff  <= s7_valid_in;
         s8_valid_ff  <= s8_valid_in;
         s9_valid_ff  <= s9_valid_in;
         s10_valid_ff <= s10_valid_in;
         s11_valid_ff <= s11_valid_in;
         s12_valid_ff <= s12_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s5_err_ff     <= s5_err_in;
      s5_serial_ff  <= s5_serial_in;
      s5_t1_ff      <= s5_t1_in;
      s6_err_ff     <= s6_err_in;
      s6_serial_ff  <= s6_serial_in;
      s6_n1_ff      <= s6_n1_in;
      s6_q_ff       <= s6_q_in;
      s7_err_ff     <= s7_err_in;
      s7_serial_ff  <= s7_serial_in;
      s7_rem_ff     <= s7_rem_in;
      s7_q_ff       <= s7_q_in;
      s8_err_ff     <= s8_err_in;
      s8_serial_ff  <= s8_serial_in;
      s8_t2_ff      <= s8_t2_in;
      s8_doc_ff     <= s8_doc_in;
      s9_err_ff     <= s9_err_in;
      s9_serial_ff  <= s9_serial_in;
      s9_t2_ff      <= s9_t2_in;
      s9_doc_ff     <= s9_doc_in;
      s9_yy_ff      <= s9_yy_in;
      s10_err_ff    <= s10_err_in;
      s10_serial_ff <= s10_serial_in;
      s10_t2_ff     <= s10_t2_in;
      s10_doc_ff    <= s10_doc_in;
      s10_yy_ff     <= s10_yy_in;
      s10_ydays_ff  <= s10_ydays_in;
      s11_err_ff    <= s11_err_in;
      s11_serial_ff <= s11_serial_in;
      s11_t2_ff     <= s11_t2_in;
      s11_yy_ff     <= s11_yy_in;
      s11_doy_ff    <= s11_doy_in;
      s12_err_ff    <= s12_err_in;
      s12_serial_ff <= s12_serial_in;
      s12_t2_ff     <= s12_t2_in;
      s12_yy_ff     <= s12_yy_in;
      s12_doy_ff    <= s12_doy_in;
      s12_mm_ff     <= s12_mm_in;
   end

endmodule

/* rtl/julian_day_date_converter.sv */
// Top level of the Julian day date converter: front and back pipelines plus
// the result register. Depends on jdc_pkg, jdc_fwd and jdc_inv.
//
// Usage: a request is taken at each rising clock edge where start is high
// and busy is low. Opcode 0 builds the source day number from month, day
// and year (a year below 100 gets 1900 added); opcode 1 takes req_in_serial
// as it is. The signed day offset is then added, and the resulting day
// number is turned back into a Gregorian date.
// Each request gives exactly one result. rsp_strobe is high for one cycle
// while the result ports carry it. If the final day number falls outside
// 0001-01-01 to 9999-12-31, rsp_range_error is set and every other result
// field reads zero.
// From the accepting edge to the edge that takes the result, four stages
// build the day number and add the offset, eight stages test its range and
// divide it into 400-year cycle, year and month (each division by a
// constant is a reciprocal multiply, at most one multiplier per stage), and
// one register holds the result. Throughput is one request per cycle, so busy
// stays low. A synchronous reset clears every valid bit; requests in
// flight are dropped and no strobe follows until a new request is taken.
// The receiver cannot stall, so results simply stream out in order.
module julian_day_date_converter
   import jdc_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic                       req_opcode,
   input  logic [MONTH_W-1:0]         req_in_month,
   input  logic [DAY_W-1:0]           req_in_day,
   input  logic [YEAR_W-1:0]          req_in_year,
   input  logic [SERIAL_W-1:0]        req_in_serial,
   input  logic signed [OFFSET_W-1:0] req_day_offset,
   output logic                       rsp_strobe,
   output logic [SERIAL_W-1:0]        rsp_out_serial,
   output logic [MONTH_W-1:0]         rsp_out_month,
   output logic [DAY_W-1:0]           rsp_out_day,
   output logic [YEAR_W-1:0]          rsp_out_year,
   output logic                       rsp_range_error
);

   jdc_jdn_type  jdn_mid;
   jdc_date_type date_end;
   logic         req_take;

   logic                rsp_strobe_ff, rsp_strobe_in;
   logic [SERIAL_W-1:0] rsp_serial_ff, rsp_serial_in;
   logic [MONTH_W-1:0]  rsp_month_ff,  rsp_month_in;
   logic [DAY_W-1:0]    rsp_day_ff,    rsp_day_in;
   logic [YEAR_W-1:0]   rsp_year_ff,   rsp_year_in;
   logic                rsp_err_ff,    rsp_err_in;

   // Every stage advances every cycle, so a new request is always welcome.
   assign busy     = 1'b0;
   assign req_take = start && !busy;

   jdc_fwd u_fwd (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_take),
      .opcode     (req_opcode),
      .in_month   (req_in_month),
      .in_day     (req_in_day),
      .in_year    (req_in_year),
      .in_serial  (req_in_serial),
      .day_offset (req_day_offset),
      .jdn_out    (jdn_mid)
   );

   jdc_inv u_inv (
      .clock    (clock),
      .reset    (reset),
      .jdn_in   (jdn_mid),
      .date_out (date_end)
   );

   // An out-of-range day number makes the back pipeline's fields meaningless,
   // so they are forced to zero here.
   always_comb begin
      rsp_strobe_in = date_end.valid;
      rsp_err_in    = date_end.range_err;
      if (date_end.range_err) begin
         rsp_serial_in = '0;
         rsp_month_in  = '0;
         rsp_day_in    = '0;
         rsp_year_in   = '0;
      end else begin
         rsp_serial_in = date_end.serial;
         rsp_month_in  = date_end.month;
         rsp_day_in    = date_end.day;
         rsp_year_in   = date_end.year;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_serial_ff <= rsp_serial_in;
      rsp_month_ff  <= rsp_month_in;
      rsp_day_ff    <= rsp_day_in;
      rsp_year_ff   <= rsp_year_in;
      rsp_err_ff    <= rsp_err_in;
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_out_serial  = rsp_serial_ff;
   assign rsp_out_month   = rsp_month_ff;
   assign rsp_out_day     = rsp_day_ff;
   assign rsp_out_year    = rsp_year_ff;
   assign rsp_range_error = rsp_err_ff;

endmodule

/* tb/tb.sv */
// Self-checking testbench of julian_day_date_converter: directed and random
// conversions are sent through the block and compared with a day number predictor.
// Depends on jdc_pkg and the converter RTL.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import jdc_pkg::*;

   // Day numbers of 0001-01-01 and 9999-12-31, the edges of the legal range.
   localparam int FIRST_DAY_NUMBER = 1721426;
   localparam int LAST_DAY_NUMBER  = 5373484;

   // One converted date as the block should report it.
   typedef struct {
      logic [SERIAL_W-1:0] serial;
      logic [MONTH_W-1:0]  month;
      logic [DAY_W-1:0]    day;
      logic [YEAR_W-1:0]   year;
      logic                range_err;
   } converted_date_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       start = 1'b0;
   logic                       busy;
   logic                       req_opcode = OP_DATE;
   logic [MONTH_W-1:0]         req_in_month = '0;
   logic [DAY_W-1:0]           req_in_day = '0;
   logic [YEAR_W-1:0]          req_in_year = '0;
   logic [SERIAL_W-1:0]        req_in_serial = '0;
   logic signed [OFFSET_W-1:0] req_day_offset = '0;
   logic                       rsp_strobe;
   logic [SERIAL_W-1:0]        rsp_out_serial;
   logic [MONTH_W-1:0]         rsp_out_month;
   logic [DAY_W-1:0]           rsp_out_day;
   logic [YEAR_W-1:0]          rsp_out_year;
   logic                       rsp_range_error;

   // Dates still owed by the block, oldest first.
   converted_date_type expected_dates[$];
   int unsigned        mismatches = 0;
   // Cleared for the stretch in which requests follow each other back to back.
   bit                 gaps_enabled = 1'b1;

   julian_day_date_converter uut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_opcode      (req_opcode),
      .req_in_month    (req_in_month),
      .req_in_day      (req_in_day),
      .req_in_year     (req_in_year),
      .req_in_serial   (req_in_serial),
      .req_day_offset  (req_day_offset),
      .rsp_strobe      (rsp_strobe),
      .rsp_out_serial  (rsp_out_serial),
      .rsp_out_month   (rsp_out_month),
      .rsp_out_day     (rsp_out_day),
      .rsp_out_year    (rsp_out_year),
      .rsp_range_error (rsp_range_error)
   );

   always #5 clock = ~clock;

   // Gregorian calendar date to Julian day number. All arithmetic is signed
   // 64-bit, so every division truncates toward zero exactly as the block's
   // formulas require, including for nonsense months and days.
   function automatic longint day_number_of(longint month, longint day, longint year);
      longint a;
      a = (month - 14) / 12;
      return day - 32075
         + 1461 * (year + 4800 + a) / 4
         + 367 * (month - 2 - a * 12) / 12
         - 3 * ((year + 4900 + a) / 100) / 4;
   endfunction

   // Works out the result of one request: pick the source day number, add
   // the offset, judge the range, then split the day number back into a date.
   function automatic converted_date_type predict_conversion(
      logic op, logic [MONTH_W-1:0] month, logic [DAY_W-1:0] day,
      logic [YEAR_W-1:0] year, logic [SERIAL_W-1:0] serial,
      logic signed [OFFSET_W-1:0] offset);
      longint             full_year, source_day, final_day;
      longint             rest, cycles, years, march_month, carry;
      converted_date_type result;
      result = '{serial: '0, month: '0, day: '0, year: '0, range_err: 1'b0};
      if (op == OP_DATE) begin
         full_year = longint'(year);
         // Two-digit years belong to the twentieth century.
         if (full_year < 100)
            full_year = full_year + 1900;
         source_day = day_number_of(longint'(month), longint'(day), full_year);
      end else begin
         source_day = longint'(serial);
      end
      final_day = source_day + longint'(offset);
      if (final_day < day_number_of(1, 1, 1) || final_day > day_number_of(12, 31, 9999)) begin
         result.range_err = 1'b1;
         return result;
      end
      // Split into 400-year cycles, years within the cycle and a March-based
      // month; the carry moves January and February into the next year.
      rest        = final_day + 68569;
      cycles      = 4 * rest / 146097;
      rest        = rest - (146097 * cycles + 3) / 4;
      years       = 4000 * (rest + 1) / 1461001;
      rest        = rest - 1461 * years / 4 + 31;
      march_month = 80 * rest / 2447;
      carry       = march_month / 11;
      result.serial = SERIAL_W'(final_day);
      result.day    = DAY_W'(rest - 2447 * march_month / 80);
      result.month  = MONTH_W'(march_month + 2 - 12 * carry);
      result.year   = YEAR_W'(100 * (cycles - 49) + years + carry);
      return result;
   endfunction

   // Hands one request to the block. It is entered at a rising edge, may idle
   // first, and returns at the edge that took the request with start still
   // high, so that the next request can follow without a gap.
   task automatic send_request(logic op, logic [MONTH_W-1:0] month,
                               logic [DAY_W-1:0] day, logic [YEAR_W-1:0] year,
                               logic [SERIAL_W-1:0] serial,
                               logic signed [OFFSET_W-1:0] offset);
      if (gaps_enabled) begin
         while ($urandom_range(99) < 30) begin
            start <= 1'b0;
            @(posedge clock);
         end
      end
      req_opcode     <= op;
      req_in_month   <= month;
      req_in_day     <= day;
      req_in_year    <= year;
      req_in_serial  <= serial;
      req_day_offset <= offset;
      start          <= 1'b1;
      // Values read right after the edge are the ones the block saw at it.
      do
         @(posedge clock);
      while (busy);
      expected_dates.push_back(predict_conversion(op, month, day, year, serial, offset));
   endtask

   // Stops sending and waits until every outstanding result has come back.
   task automatic wait_for_results();
      start <= 1'b0;
      while (expected_dates.size() != 0)
         @(posedge clock);
   endtask

   // A request from calendar fields: mostly sane dates in all year ranges,
   // sometimes malformed months and days or years past 9999. The unused day
   // number field carries noise.
   task automatic send_random_date();
      logic [MONTH_W-1:0]         month;
      logic [DAY_W-1:0]           day;
      logic [YEAR_W-1:0]          year;
      logic signed [OFFSET_W-1:0] offset;
      month = ($urandom_range(9) != 0) ? MONTH_W'($urandom_range(12, 1))
                                       : MONTH_W'($urandom_range(15, 0));
      day   = ($urandom_range(9) < 7) ? DAY_W'($urandom_range(28, 1))
                                      : DAY_W'($urandom_range(31, 0));
      case ($urandom_range(9))
         0, 1:    year = YEAR_W'($urandom_range(99, 0));
         2:       year = YEAR_W'($urandom_range(16383, 0));
         default: year = YEAR_W'($urandom_range(9999, 100));
      endcase
      if ($urandom_range(3) == 0)
         offset = OFFSET_W'($urandom());
      else
         offset = OFFSET_W'(int'($urandom_range(4000)) - 2000);
      send_request(OP_DATE, month, day, year, SERIAL_W'($urandom()), offset);
   endtask

   // A request from the day number field: mostly around the legal range,
   // sometimes anywhere in the field. Unused date fields carry noise.
   task automatic send_random_day_number();
      logic [SERIAL_W-1:0]        serial;
      logic signed [OFFSET_W-1:0] offset;
      if ($urandom_range(4) != 0)
         serial = SERIAL_W'($urandom_range(LAST_DAY_NUMBER + 3000, FIRST_DAY_NUMBER - 3000));
      else
         serial = SERIAL_W'($urandom());
      if ($urandom_range(2) == 0)
         offset = OFFSET_W'($urandom());
      else
         offset = OFFSET_W'(int'($urandom_range(4000)) - 2000);
      send_request(OP_SERIAL, MONTH_W'($urandom()), DAY_W'($urandom()),
                   YEAR_W'($urandom()), serial, offset);
   endtask

   // Field extremes, both opcodes, the century rule, leap days, malformed
   // dates and both edges of the legal range.
   task automatic test_directed_cases();
      send_request(OP_SERIAL, 0, 0, 0, SERIAL_W'(FIRST_DAY_NUMBER), 0);
      send_request(OP_SERIAL, 0, 0, 0, SERIAL_W'(FIRST_DAY_NUMBER - 1), 0);
      send_request(OP_SERIAL, 0, 0, 0, SERIAL_W'(LAST_DAY_NUMBER), 0);
      send_request(OP_SERIAL, 0, 0, 0, SERIAL_W'(LAST_DAY_NUMBER), 1);
      send_request(OP_SERIAL, 0, 0, 0, 0, 0);
      send_request(OP_SERIAL, 0, 0, 0, 23'h7FFFFF, -21'sd1048576);
      send_request(OP_SERIAL, 0, 0, 0, 0, 21'sd1048575);
      send_request(OP_SERIAL, 0, 0, 0, SERIAL_W'(FIRST_DAY_NUMBER + 1048576), -21'sd1048576);
      // Unused date fields all ones must not disturb a day number request.
      send_request(OP_SERIAL, 4'hF, 5'h1F, 14'h3FFF, 2451545, 0);
      send_request(OP_DATE, 12, 31, 9999, 0, 0);
      send_request(OP_DATE, 12, 31, 9999, 0, 1);
      send_request(OP_DATE, 1, 1, 0, 0, 0);
      send_request(OP_DATE, 12, 31, 99, 0, 0);
      send_request(OP_DATE, 1, 1, 100, 0, 0);
      // 0100-01-01 lies 36159 days after 0001-01-01.
      send_request(OP_DATE, 1, 1, 100, 0, -21'sd36159);
      send_request(OP_DATE, 1, 1, 100, 0, -21'sd36160);
      send_request(OP_DATE, 2, 29, 2000, 0, 0);
      send_request(OP_DATE, 2, 29, 1900, 0, 0);
      send_request(OP_DATE, 0, 0, 2024, 0, 0);
      send_request(OP_DATE, 15, 31, 2024, 0, 0);
      send_request(OP_DATE, 13, 31, 16383, 0, 0);
      send_request(OP_DATE, 6, 15, 1000, 0, 21'sd1048575);
      send_request(OP_DATE, 6, 15, 1000, 0, -21'sd1048576);
      // Year 1 is taken as 1901; the unused day number field is all ones.
      send_request(OP_DATE, 1, 1, 1, 23'h7FFFFF, 0);
   endtask

   task automatic test_random_dates();
      repeat (450) send_random_date();
   endtask

   task automatic test_random_day_numbers();
      repeat (450) send_random_day_number();
   endtask

   // Final day numbers within a few days of either edge of the legal range,
   // reached through offsets of either sign.
   task automatic test_range_edges();
      int boundary_day;
      int offset_days;
      repeat (100) begin
         boundary_day = $urandom_range(1) ? FIRST_DAY_NUMBER : LAST_DAY_NUMBER;
         offset_days  = int'($urandom_range(200000)) - 100000;
         send_request(OP_SERIAL, MONTH_W'($urandom()), DAY_W'($urandom()),
                      YEAR_W'($urandom()),
                      SERIAL_W'(boundary_day + int'($urandom_range(20)) - 10 - offset_days),
                      OFFSET_W'(offset_days));
      end
   endtask

   // A long run without idle cycles keeps the whole pipeline full.
   task automatic test_back_to_back();
      gaps_enabled = 1'b0;
      repeat (200) begin
         if ($urandom_range(1))
            send_random_date();
         else
            send_random_day_number();
      end
      gaps_enabled = 1'b1;
   endtask

   // Each strobe is matched with the oldest outstanding request. The result
   // ports are read right after the edge, so they hold the values that the
   // edge accepted.
   always @(posedge clock) begin
      converted_date_type want;
      if (!reset && rsp_strobe) begin
         if (expected_dates.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: result with no request outstanding", $realtime);
         end else begin
            want = expected_dates.pop_front();
            if (rsp_out_serial !== want.serial || rsp_out_month !== want.month ||
                rsp_out_day !== want.day || rsp_out_year !== want.year ||
                rsp_range_error !== want.range_err) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: expected %0d %0d/%0d/%0d err %0b, got %0d %0d/%0d/%0d err %0b",
                           $realtime, want.serial, want.month, want.day, want.year,
                           want.range_err, rsp_out_serial, rsp_out_month, rsp_out_day,
                           rsp_out_year, rsp_range_error);
            end
         end
      end
   end

   // Main sequence. Reset is held from the start and released once. The
   // pause after the random dates lets the pipeline empty completely before
   // traffic resumes. At the end the bench waits for every result, then keeps
   // watching for stray strobes before it reports.
   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_cases();
      test_random_dates();
      wait_for_results();
      test_back_to_back();
      test_random_day_numbers();
      test_range_edges();
      wait_for_results();
      repeat (20) @(posedge clock);
      if (mismatches == 0 && expected_dates.size() == 0)
         $display("julian_day_date_converter verification clean");
      else
         $display("julian_day_date_converter verification failed");
      $finish;
   end

   // A correct run ends well before this bound.
   initial begin
      #5_000_000;
      $display("julian_day_date_converter verification failed");
      $finish;
   end

endmodule

/* sim.f */
rtl/jdc_pkg.sv
rtl/jdc_fwd.sv
rtl/jdc_inv.sv
rtl/julian_day_date_converter.sv
tb/tb.sv
